// ===== hdl/bpc_pkg.sv =====
package bpc_pkg;

	// Fraction bits of the Q16.16 format; also the number of quotient bits of the fade position.
	localparam int Q = 16;

	// Unity in unsigned Q1.16 as a 17-bit value.
	localparam logic [Q:0] ONE_Q16 = 17'h10000;

	// Reset value of the fade margin fraction.
	localparam logic [15:0] BLEND_FRAC_RST = 16'd6554;

	typedef enum logic [2:0] {
		REG_DEGREE     = 3'd0,
		REG_COEFF_A    = 3'd1,
		REG_COEFF_B    = 3'd2,
		REG_COEFF_C    = 3'd3,
		REG_COEFF_D    = 3'd4,
		REG_RANGE_LOW  = 3'd5,
		REG_RANGE_HIGH = 3'd6,
		REG_BLEND_FRAC = 3'd7
	} reg_idx_t;

	// Setup for one fade division: the numerator is clamped in front of the divider.
	typedef struct packed {
		logic        zero;
		logic        full;
		logic [31:0] rem;
	} div_in_t;

endpackage

// ===== hdl/bpc_divider.sv =====
module bpc_divider (
	input  logic             clk,
	input  logic             en,
	input  bpc_pkg::div_in_t din,
	input  logic [31:0]      margin,
	output logic [16:0]      t
);
	import bpc_pkg::*;

	logic [31:0]  r_s    [1:Q];
	logic [Q-1:0] q_s    [1:Q];
	logic         zero_s [1:Q];
	logic         full_s [1:Q];

	logic [31:0]  r_nx [1:Q];
	logic [Q-1:0] q_nx [1:Q];

	// One restoring step: shift the remainder, subtract the margin where it fits.
	function automatic logic [31+Q:0] div_step(input logic [31:0] r, input logic [Q-1:0] q);
		logic [32:0] r2;
		r2 = {r, 1'b0};
		if (r2 >= {1'b0, margin})
			return {32'(r2 - {1'b0, margin}), q[Q-2:0], 1'b1};
		return {r2[31:0], q[Q-2:0], 1'b0};
	endfunction

	// One step per stage; the remainder stays below the margin whenever it starts below it.
	always_comb begin
		{r_nx[1], q_nx[1]} = div_step(din.rem, '0);
		for (int j = 2; j <= Q; j++) begin
			{r_nx[j], q_nx[j]} = div_step(r_s[j-1], q_s[j-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[1] <= din.zero;
			full_s[1] <= din.full;
			for (int j = 1; j <= Q; j++) begin
				r_s[j] <= r_nx[j];
				q_s[j] <= q_nx[j];
			end
			for (int j = 2; j <= Q; j++) begin
				zero_s[j] <= zero_s[j-1];
				full_s[j] <= full_s[j-1];
			end
		end
	end

	assign t = zero_s[Q] ? '0 : (full_s[Q] ? ONE_Q16 : {1'b0, q_s[Q]});

endmodule

// ===== hdl/bpc_fade.sv =====
module bpc_fade (
	input  logic        clk,
	input  logic        en,
	input  logic [16:0] t,
	output logic [16:0] s
);
	import bpc_pkg::*;

	logic [16:0] t_s1;
	logic [16:0] t2_s1;
	logic [16:0] s_s2;

	logic [33:0] sq;
	logic [17:0] fac;
	logic [35:0] cub;
	logic [19:0] sv;

	assign sq  = 34'(t) * 34'(t) + 34'h8000;
	assign fac = 18'd196608 - {t_s1, 1'b0};
	assign cub = 36'(t2_s1) * 36'(fac) + 36'h8000;
	assign sv  = cub[35:16];

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= t;
			t2_s1 <= sq[32:16];
			s_s2  <= (sv > 20'(ONE_Q16)) ? ONE_Q16 : sv[16:0];
		end
	end

	assign s = s_s2;

endmodule

// ===== hdl/blended_polynomial_correction_unit.sv =====
// Blended polynomial correction. Each distance beat (signed Q16.16) yields one correction
// beat: a polynomial of up to MAX_DEGREE evaluated by Horner's rule with rounding and
// saturation per step, then scaled by a smoothstep window that is 1 inside
// [range_low, range_high] and fades to 0 across a margin of blend_frac times the range on
// either side. The saturated flag reports clipping in any Horner step. The block takes one
// beat per clock unless stalled, and each result passes the preparation stages, the
// 16-stage fade divider (one quotient bit per stage) and the smoothstep, weight and
// scaling stages. A stall on the output freezes the whole pipeline, so the input
// stalls only while a finished result waits and is not taken. Registers are written
// through the plain write port and must only be changed while no beat is in flight.
module blended_polynomial_correction_unit #(
	parameter int MAX_DEGREE = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] distance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] correction,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import bpc_pkg::*;

	// Stage where the Horner result is final, and the output stage.
	localparam int HE   = 2 * MAX_DEGREE + 1;
	localparam int LAST = Q + 6;
	localparam logic [1:0] MAXD = MAX_DEGREE[1:0];

	// Configuration registers.
	logic [1:0]         degree_q;
	logic signed [31:0] coeff_a_q, coeff_b_q, coeff_c_q, coeff_d_q;
	logic signed [31:0] range_low_q, range_high_q;
	logic [15:0]        blend_frac_q;
	logic [31:0]        margin_q;
	logic               win_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q     <= '0;
			coeff_a_q    <= '0;
			coeff_b_q    <= '0;
			coeff_c_q    <= '0;
			coeff_d_q    <= '0;
			range_low_q  <= '0;
			range_high_q <= '0;
			blend_frac_q <= BLEND_FRAC_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_DEGREE:     degree_q     <= cfg_data[1:0];
				REG_COEFF_A:    coeff_a_q    <= cfg_data;
				REG_COEFF_B:    coeff_b_q    <= cfg_data;
				REG_COEFF_C:    coeff_c_q    <= cfg_data;
				REG_COEFF_D:    coeff_d_q    <= cfg_data;
				REG_RANGE_LOW:  range_low_q  <= cfg_data;
				REG_RANGE_HIGH: range_high_q <= cfg_data;
				REG_BLEND_FRAC: blend_frac_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The margin follows the range registers in the next cycle. It is first needed in the
	// second stage, so a beat accepted right after a write already sees the new value.
	logic signed [32:0] rng;
	logic [48:0]        mprod;
	logic [31:0]        margin_nx;

	assign rng       = {range_high_q[31], range_high_q} - {range_low_q[31], range_low_q};
	assign mprod     = 49'(rng[32:0]) * 49'(blend_frac_q);
	assign margin_nx = mprod[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= '0;
			win_en_q <= 1'b0;
		end else begin
			margin_q <= margin_nx;
			win_en_q <= (range_low_q < range_high_q) && (margin_nx != '0);
		end
	end

	// The whole pipeline moves together unless a finished result is held on the output.
	logic adv;
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic [1:0]         deg_eff;
	logic signed [31:0] co [0:3];
	assign deg_eff = (degree_q > MAXD) ? MAXD : degree_q;
	always_comb begin
		co[0] = coeff_a_q;
		co[1] = coeff_b_q;
		co[2] = coeff_c_q;
		co[3] = coeff_d_q;
	end

	logic               vld_s  [1:LAST];
	logic signed [31:0] acc_s  [1:LAST];
	logic               sat_s  [1:LAST];
	logic signed [31:0] d_s    [1:HE];
	logic signed [63:0] prod_s [1:HE];

	logic signed [31:0] acc_nx  [1:LAST];
	logic               sat_nx  [1:LAST];
	logic signed [63:0] prod_nx [1:HE];

	logic [16:0] w_s21;

	// Horner steps alternate a multiply stage and a round, add and saturate stage. A step
	// beyond the degree in use passes the accumulator on. The last stage applies the weight.
	always_comb begin
		int                 k;
		logic signed [63:0] sum;
		logic signed [49:0] wp;
		for (int j = 1; j <= HE; j++) begin
			prod_nx[j] = '0;
		end
		acc_nx[1] = '0;
		sat_nx[1] = 1'b0;
		for (int j = 2; j <= LAST; j++) begin
			acc_nx[j] = acc_s[j-1];
			sat_nx[j] = sat_s[j-1];
			k         = (j - 1) / 2;
			sum       = '0;
			wp        = '0;
			if (j <= HE && (j % 2) == 0) begin
				prod_nx[j] = acc_s[j-1] * d_s[j-1];
			end else if (j <= HE && 2'(k) <= deg_eff) begin
				sum = ((prod_s[j-1] + 64'sd32768) >>> 16) + 64'(co[k]);
				if (sum > 64'sd2147483647) begin
					acc_nx[j] = 32'sh7FFFFFFF;
					sat_nx[j] = 1'b1;
				end else if (sum < -64'sd2147483648) begin
					acc_nx[j] = 32'sh80000000;
					sat_nx[j] = 1'b1;
				end else begin
					acc_nx[j] = sum[31:0];
				end
			end
			if (j == LAST) begin
				wp        = acc_s[j-1] * $signed({1'b0, w_s21}) + 50'sd32768;
				acc_nx[j] = wp[47:16];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= LAST; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int j = 2; j <= LAST; j++) begin
				vld_s[j] <= vld_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s[1]    <= distance;
			acc_s[1]  <= coeff_a_q;
			sat_s[1]  <= 1'b0;
			prod_s[1] <= prod_nx[1];
			for (int j = 2; j <= HE; j++) begin
				d_s[j]    <= d_s[j-1];
				prod_s[j] <= prod_nx[j];
			end
			for (int j = 2; j <= LAST; j++) begin
				acc_s[j] <= acc_nx[j];
				sat_s[j] <= sat_nx[j];
			end
		end
	end

	// Fade numerators, clamped to [0, margin] before the dividers.
	logic signed [34:0] m35, nl, nh;
	div_in_t            div_lo_s2, div_hi_s2;

	assign m35 = $signed({3'b000, margin_q});
	assign nl  = 35'(d_s[1]) - 35'(range_low_q) + m35;
	assign nh  = 35'(range_high_q) + m35 - 35'(d_s[1]);

	always_ff @(posedge clk) begin
		if (adv) begin
			div_lo_s2.zero <= (nl <= 35'sd0);
			div_lo_s2.full <= (nl >= m35);
			div_lo_s2.rem  <= nl[31:0];
			div_hi_s2.zero <= (nh <= 35'sd0);
			div_hi_s2.full <= (nh >= m35);
			div_hi_s2.rem  <= nh[31:0];
		end
	end

	logic [16:0] t_lo, t_hi, s_lo, s_hi;

	bpc_divider u_div_lo (.clk(clk), .en(adv), .din(div_lo_s2), .margin(margin_q), .t(t_lo));
	bpc_divider u_div_hi (.clk(clk), .en(adv), .din(div_hi_s2), .margin(margin_q), .t(t_hi));

	bpc_fade u_fade_lo (.clk(clk), .en(adv), .t(t_lo), .s(s_lo));
	bpc_fade u_fade_hi (.clk(clk), .en(adv), .t(t_hi), .s(s_hi));

	// Combined window weight; unity when the window is off.
	logic [33:0] wprod;
	assign wprod = 34'(s_lo) * 34'(s_hi) + 34'h8000;

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s21 <= win_en_q ? wprod[32:16] : ONE_Q16;
		end
	end

	assign out_valid  = vld_s[LAST];
	assign correction = acc_s[LAST];
	assign saturated  = sat_s[LAST];

endmodule

// ===== hdl/bpc_checker.sv =====
module bpc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] correction,
	input logic               saturated
);

	// A held result keeps its value and flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(correction) && $stable(saturated))
		else $error("held result changed");

	// The input only stalls while a finished result is held on the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// Nothing comes out on the first edge after reset.
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result present right after reset");

	// An input offered while the output is free is taken.
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !out_valid |-> !in_stall)
		else $error("input refused while output is free");

endmodule

bind blended_polynomial_correction_unit bpc_checker u_bpc_checker (.*);
